// File: rtl/prim_mst_pkg.sv
package prim_mst_pkg;

	localparam int TREE_W = 21;
	localparam int NCFG_W = 6;

	localparam logic [1:0] ACT_LOAD    = 2'd0;
	localparam logic [1:0] ACT_COMPUTE = 2'd1;
	localparam logic [1:0] ACT_CLEAR   = 2'd2;

	typedef struct packed {
		logic [1:0]  action;
		logic [1:0]  scenario;
		logic [4:0]  node_a;
		logic [4:0]  node_b;
		logic [15:0] edge_weight;
	} in_item_t;

	typedef struct packed {
		logic [TREE_W-1:0] tree_weight;
		logic              disconnected;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOAD_RA,
		ST_LOAD_WA,
		ST_LOAD_RB,
		ST_LOAD_WB,
		ST_INIT,
		ST_PICK,
		ST_RELAX,
		ST_RWAIT,
		ST_CHOOSE,
		ST_DONE
	} state_t;

endpackage

// File: rtl/prim_minimum_spanning_tree_top.sv
// Minimum spanning tree weight, dense Prim grown from node 0. A load beat marks the
// edge node_a/node_b present and stores its weight for one scenario; a clear beat
// wipes the edge map; a compute beat returns one result with the tree weight over
// nodes 0..node_count-1 and a disconnected flag. The node keys live in a
// single-read-port RAM that is swept one node per cycle for every node added to
// the tree, while the adjacency row of the added node comes from the edge map in
// one read. After reset the edge map is cleared in a pass during which no beat is
// taken; node_count writes are taken at any time. The result sits in an output
// register, so the next beat is taken while it waits.
module prim_minimum_spanning_tree_top import prim_mst_pkg::*; #(
	parameter int MAX_NODES     = 32,
	parameter int MAX_SCENARIOS = 4,
	parameter int WEIGHT_BITS   = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [NCFG_W-1:0] cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  in_item_t          in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output out_item_t         out_data
);

	localparam int NW         = $clog2(MAX_NODES);
	localparam int NCW        = $clog2(MAX_NODES + 1);
	localparam int SW         = (MAX_SCENARIOS > 1) ? $clog2(MAX_SCENARIOS) : 1;
	localparam int PAIR_COUNT = MAX_NODES * MAX_NODES;
	localparam int WDEPTH     = MAX_SCENARIOS * PAIR_COUNT;
	localparam int WAW        = $clog2(WDEPTH);
	localparam int KW         = WEIGHT_BITS + 1;
	localparam int ADD_W      = ((KW > TREE_W) ? KW : TREE_W) + 1;
	localparam logic [KW-1:0]     KEY_INF   = {1'b1, {WEIGHT_BITS{1'b0}}};
	localparam logic [TREE_W-1:0] SUM_MAX   = {TREE_W{1'b1}};
	localparam logic [NW-1:0]     NODE_LAST = NW'(MAX_NODES - 1);

	function automatic logic [WAW-1:0] wt_addr(logic [SW-1:0] s, logic [NW-1:0] a,
			logic [NW-1:0] b);
		logic [31:0] full;
		full = 32'(s) * 32'(PAIR_COUNT) + 32'(a) * 32'(MAX_NODES) + 32'(b);
		return full[WAW-1:0];
	endfunction

	function automatic logic [SW-1:0] scen_wrap(logic [1:0] s);
		logic [1:0] r;
		r = s;
		for (int i = 0; i < 3; i++) begin
			if (32'(r) >= MAX_SCENARIOS) begin
				r = r - 2'(MAX_SCENARIOS);
			end
		end
		return SW'(r);
	endfunction

	state_t state_q, state_d;

	logic [NCFG_W-1:0]  node_count_q;
	logic [NW-1:0]      v_q;
	logic [NW-1:0]      v_s1;
	logic               rv_s1;
	logic               out_valid_q;
	out_item_t          out_data_q;

	logic [SW-1:0]          s_q;
	logic [NW-1:0]          a_q, b_q;
	logic [WEIGHT_BITS-1:0] w_q;
	logic [NCW-1:0]         n_q;
	logic [NW-1:0]          nlast_q;
	logic [NCW-1:0]         added_q;
	logic [TREE_W-1:0]      sum_q;
	logic                   cut_q;
	logic [NW-1:0]          pick_q, pick_run_q;
	logic [KW-1:0]          best_q, best_run_q;

	logic [NCW-1:0]    n_eff;
	logic [ADD_W-1:0]  sum_ext;
	logic [TREE_W-1:0] sum_next;
	logic              load_ok;
	logic              take_out;
	logic              last_add;

	// memory ports
	logic                   row_we, row_re;
	logic [NW-1:0]          row_waddr, row_raddr;
	logic [MAX_NODES-1:0]   row_wdata, row_rdata;
	logic                   wt_we, wt_re;
	logic [WAW-1:0]         wt_waddr, wt_raddr;
	logic [WEIGHT_BITS-1:0] wt_wdata, wt_rdata;
	logic                   key_we, key_re;
	logic [NW-1:0]          key_waddr, key_raddr;
	logic [KW:0]            key_wdata, key_rdata;

	// relax stage
	logic          s1_intree, s1_is_pick, s1_cand, s1_lower, s1_we, s1_better;
	logic [KW-1:0] s1_key, s1_w, s1_key_new;
	logic [KW:0]   s1_wdata;

	prim_mst_ram #(.WIDTH(MAX_NODES), .DEPTH(MAX_NODES)) u_row_ram (
		.clk   (clk),
		.we    (row_we),
		.waddr (row_waddr),
		.wdata (row_wdata),
		.re    (row_re),
		.raddr (row_raddr),
		.rdata (row_rdata)
	);

	prim_mst_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(WDEPTH)) u_wt_ram (
		.clk   (clk),
		.we    (wt_we),
		.waddr (wt_waddr),
		.wdata (wt_wdata),
		.re    (wt_re),
		.raddr (wt_raddr),
		.rdata (wt_rdata)
	);

	prim_mst_ram #(.WIDTH(KW + 1), .DEPTH(MAX_NODES)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (key_waddr),
		.wdata (key_wdata),
		.re    (key_re),
		.raddr (key_raddr),
		.rdata (key_rdata)
	);

	always_comb begin
		if (node_count_q == '0) begin
			n_eff = NCW'(1);
		end else if (32'(node_count_q) > MAX_NODES) begin
			n_eff = NCW'(MAX_NODES);
		end else begin
			n_eff = NCW'(node_count_q);
		end
	end

	assign load_ok = (32'(in_data.node_a) < MAX_NODES) && (32'(in_data.node_b) < MAX_NODES);
	assign take_out = !out_valid_q || !out_stall;
	assign last_add = (added_q + NCW'(1)) == n_q;

	// saturate on every add; the sum only grows, so this matches saturating at the end
	always_comb begin
		sum_ext = ADD_W'(sum_q) + ADD_W'(best_q);
		if (sum_ext > ADD_W'(SUM_MAX)) begin
			sum_next = SUM_MAX;
		end else begin
			sum_next = sum_ext[TREE_W-1:0];
		end
	end

	// relax one neighbor of the picked node and track the next smallest key
	always_comb begin
		s1_intree  = key_rdata[KW];
		s1_key     = key_rdata[KW-1:0];
		s1_w       = {1'b0, wt_rdata};
		s1_is_pick = v_s1 == pick_q;
		s1_cand    = rv_s1 && !s1_intree && !s1_is_pick;
		s1_lower   = s1_cand && row_rdata[v_s1] && (s1_w < s1_key);
		s1_key_new = s1_lower ? s1_w : s1_key;
		s1_we      = rv_s1 && (s1_is_pick || s1_lower);
		s1_wdata   = s1_is_pick ? {1'b1, s1_key} : {1'b0, s1_key_new};
		s1_better  = s1_cand && (s1_key_new < best_run_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_stall  = state_q != ST_IDLE;
		row_we    = 1'b0;
		row_waddr = v_q;
		row_wdata = '0;
		row_re    = 1'b0;
		row_raddr = pick_q;
		wt_we     = 1'b0;
		wt_waddr  = wt_addr(s_q, a_q, b_q);
		wt_wdata  = w_q;
		wt_re     = 1'b0;
		wt_raddr  = wt_addr(s_q, pick_q, v_q);
		key_re    = 1'b0;
		key_raddr = v_q;
		key_we    = s1_we;
		key_waddr = v_s1;
		key_wdata = s1_wdata;
		case (state_q)
			ST_CLEAR: begin
				row_we = 1'b1;
				if (v_q == NODE_LAST) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					case (in_data.action)
						ACT_LOAD: begin
							if (load_ok) begin
								state_d = ST_LOAD_RA;
							end
						end
						ACT_COMPUTE: state_d = ST_INIT;
						ACT_CLEAR:   state_d = ST_CLEAR;
						default:     state_d = ST_IDLE;
					endcase
				end
			end
			ST_LOAD_RA: begin
				row_re    = 1'b1;
				row_raddr = a_q;
				wt_we     = 1'b1;
				state_d   = ST_LOAD_WA;
			end
			ST_LOAD_WA: begin
				row_we    = 1'b1;
				row_waddr = a_q;
				row_wdata = row_rdata | ({{(MAX_NODES-1){1'b0}}, 1'b1} << b_q);
				state_d   = ST_LOAD_RB;
			end
			ST_LOAD_RB: begin
				row_re    = 1'b1;
				row_raddr = b_q;
				wt_we     = 1'b1;
				wt_waddr  = wt_addr(s_q, b_q, a_q);
				state_d   = ST_LOAD_WB;
			end
			ST_LOAD_WB: begin
				row_we    = 1'b1;
				row_waddr = b_q;
				row_wdata = row_rdata | ({{(MAX_NODES-1){1'b0}}, 1'b1} << a_q);
				state_d   = ST_IDLE;
			end
			ST_INIT: begin
				key_we    = 1'b1;
				key_waddr = v_q;
				key_wdata = {1'b0, (v_q == '0) ? {KW{1'b0}} : KEY_INF};
				if (v_q == nlast_q) begin
					state_d = ST_PICK;
				end
			end
			ST_PICK: begin
				if (last_add) begin
					state_d = ST_DONE;
				end else begin
					row_re  = 1'b1;
					state_d = ST_RELAX;
				end
			end
			ST_RELAX: begin
				key_re = 1'b1;
				wt_re  = 1'b1;
				if (v_q == nlast_q) begin
					state_d = ST_RWAIT;
				end
			end
			ST_RWAIT: state_d = ST_CHOOSE;
			ST_CHOOSE: begin
				state_d = (best_run_q == KEY_INF) ? ST_DONE : ST_PICK;
			end
			ST_DONE: begin
				if (take_out) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NCFG_W'(1);
			v_q          <= '0;
			rv_s1        <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				node_count_q <= cfg_data;
			end
			rv_s1 <= state_q == ST_RELAX;
			case (state_q)
				ST_CLEAR, ST_INIT, ST_RELAX: v_q <= v_q + NW'(1);
				ST_IDLE, ST_PICK:            v_q <= '0;
				default:                     v_q <= v_q;
			endcase
			if (state_q == ST_DONE && take_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		v_s1 <= v_q;
		if (state_q == ST_IDLE && in_valid) begin
			s_q     <= scen_wrap(in_data.scenario);
			a_q     <= NW'(in_data.node_a);
			b_q     <= NW'(in_data.node_b);
			w_q     <= WEIGHT_BITS'(in_data.edge_weight);
			n_q     <= n_eff;
			nlast_q <= NW'(n_eff - NCW'(1));
			sum_q   <= '0;
			added_q <= '0;
			cut_q   <= 1'b0;
		end
		if (state_q == ST_INIT) begin
			pick_q <= '0;
			best_q <= '0;
		end
		if (state_q == ST_PICK) begin
			sum_q      <= sum_next;
			added_q    <= added_q + NCW'(1);
			best_run_q <= KEY_INF;
		end
		if (s1_better) begin
			best_run_q <= s1_key_new;
			pick_run_q <= v_s1;
		end
		if (state_q == ST_CHOOSE) begin
			if (best_run_q == KEY_INF) begin
				cut_q <= 1'b1;
			end else begin
				pick_q <= pick_run_q;
				best_q <= best_run_q;
			end
		end
		if (state_q == ST_DONE && take_out) begin
			out_data_q.tree_weight  <= sum_q;
			out_data_q.disconnected <= cut_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_key_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(key_we && key_re) |-> (key_waddr != key_raddr))
		else $error("key RAM written and read at the same entry");

	a_pick_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PICK) |-> (added_q < n_q))
		else $error("more nodes added than in use");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised outside a finished compute");

	a_s1_origin: assert property (@(posedge clk) disable iff (!arst_n)
		s1_we |-> $past(state_q == ST_RELAX))
		else $error("key write-back without a relax read");

	a_cut_partial: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && cut_q) |-> (added_q < n_q))
		else $error("disconnected flagged with every node reached");

endmodule

// File: rtl/prim_mst_ram.sv
module prim_mst_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import prim_mst_pkg::*;

	localparam int NODES      = 32;
	localparam int SCENARIOS  = 4;
	localparam int GAP_MAX    = 13;
	localparam int SETTLE     = 40;
	localparam int STUCK_MAX  = 20000;
	localparam int SUM_CAP    = (1 << TREE_W) - 1;
	localparam logic [1:0] ACT_NONE = 2'd3;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [NCFG_W-1:0] cfg_data;
	logic              in_valid;
	logic              in_stall;
	in_item_t          in_data;
	logic              out_valid;
	logic              out_stall;
	out_item_t         out_data;

	prim_minimum_spanning_tree_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	// predictor state: shared edge map, per-scenario weights and which were written
	bit          edge_on   [NODES][NODES];
	logic [15:0] edge_wt   [SCENARIOS][NODES][NODES];
	bit          wt_known  [SCENARIOS][NODES][NODES];
	int          nodes_used;

	out_item_t   tree_q[$];

	bit idle_on;
	int hold_left;
	int stall_mark;
	int errors;
	int items_sent;
	int loads_sent;
	int clears_sent;
	int computes_sent;
	int trees_checked;
	int disc_seen;
	int stuck_cycles;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic out_item_t mst_total(input logic [1:0] scen);
		bit          joined [NODES];
		logic [16:0] reach_cost [NODES];
		logic [16:0] best;
		int          pick;
		int          added;
		int unsigned sum;
		out_item_t   res;
		for (int v = 0; v < NODES; v++) begin
			joined[v] = 1'b0;
			reach_cost[v] = 17'h10000;
		end
		reach_cost[0] = '0;
		sum = 0;
		res.disconnected = 1'b0;
		for (added = 0; added < nodes_used; added++) begin
			best = 17'h10000;
			pick = -1;
			for (int v = 0; v < nodes_used; v++) begin
				if (!joined[v] && reach_cost[v] < best) begin
					best = reach_cost[v];
					pick = v;
				end
			end
			if (pick < 0) begin
				res.disconnected = 1'b1;
				break;
			end
			joined[pick] = 1'b1;
			sum += 32'(best);
			for (int v = 0; v < nodes_used; v++) begin
				if (!joined[v] && edge_on[pick][v] &&
				    {1'b0, edge_wt[scen][pick][v]} < reach_cost[v])
					reach_cost[v] = {1'b0, edge_wt[scen][pick][v]};
			end
		end
		if (sum > SUM_CAP)
			sum = SUM_CAP;
		res.tree_weight = sum[TREE_W-1:0];
		return res;
	endfunction

	// a compute may only touch weights that were written for its scenario
	function automatic bit scen_ready(input int scen);
		for (int a = 0; a < nodes_used; a++)
			for (int b = 0; b < nodes_used; b++)
				if (a != b && edge_on[a][b] && !wt_known[scen][a][b])
					return 1'b0;
		return 1'b1;
	endfunction

	task automatic apply_beat(input in_item_t b);
		case (b.action)
			ACT_LOAD: begin
				edge_on[b.node_a][b.node_b] = 1'b1;
				edge_on[b.node_b][b.node_a] = 1'b1;
				edge_wt[b.scenario][b.node_a][b.node_b] = b.edge_weight;
				edge_wt[b.scenario][b.node_b][b.node_a] = b.edge_weight;
				wt_known[b.scenario][b.node_a][b.node_b] = 1'b1;
				wt_known[b.scenario][b.node_b][b.node_a] = 1'b1;
				loads_sent++;
			end
			ACT_COMPUTE: begin
				tree_q = {tree_q, mst_total(b.scenario)};
				computes_sent++;
			end
			ACT_CLEAR: begin
				for (int a = 0; a < NODES; a++)
					for (int c = 0; c < NODES; c++)
						edge_on[a][c] = 1'b0;
				clears_sent++;
			end
			default: ;
		endcase
		if (b.action != ACT_NONE)
			items_sent++;
	endtask

	// called at a falling edge; returns at the falling edge after the beat went in
	task automatic send_beat(input in_item_t b);
		int gap;
		gap = idle_on ? $urandom_range(0, GAP_MAX) : 0;
		repeat (gap) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_data  = b;
		do @(posedge clk); while (in_stall);
		apply_beat(b);
		@(negedge clk);
	endtask

	function automatic in_item_t make_beat(input logic [1:0] act, input logic [1:0] scen,
	                                       input int a, input int b, input int w);
		in_item_t it;
		it.action      = act;
		it.scenario    = scen;
		it.node_a      = a[4:0];
		it.node_b      = b[4:0];
		it.edge_weight = w[15:0];
		return it;
	endfunction

	function automatic int rand_weight();
		case ($urandom_range(0, 5))
			0:       return 0;
			1:       return 32'hFFFF;
			2:       return $urandom_range(0, 7);
			default: return $urandom_range(0, 32'hFFFF);
		endcase
	endfunction

	task automatic send_load(input int scen, input int a, input int b, input int w);
		send_beat(make_beat(ACT_LOAD, scen[1:0], a, b, w));
	endtask

	task automatic send_compute(input int scen);
		send_beat(make_beat(ACT_COMPUTE, scen[1:0], $urandom_range(0, 31),
		                    $urandom_range(0, 31), $urandom_range(0, 32'hFFFF)));
	endtask

	task automatic send_clear();
		send_beat(make_beat(ACT_CLEAR, 2'($urandom_range(0, 3)), $urandom_range(0, 31),
		                    $urandom_range(0, 31), $urandom_range(0, 32'hFFFF)));
	endtask

	task automatic send_unused();
		send_beat(make_beat(ACT_NONE, 2'($urandom_range(0, 3)), $urandom_range(0, 31),
		                    $urandom_range(0, 31), $urandom_range(0, 32'hFFFF)));
	endtask

	// drain, let a trailing load or clear finish, then write node_count
	task automatic set_nodes(input int value);
		in_valid = 1'b0;
		while (tree_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
		cfg_we   = 1'b1;
		cfg_data = value[NCFG_W-1:0];
		@(negedge clk);
		cfg_we   = 1'b0;
		nodes_used = (value[NCFG_W-1:0] == 0) ? 1 :
		             (value[NCFG_W-1:0] > NODES) ? NODES : int'(value[NCFG_W-1:0]);
	endtask

	// result side: new stall draw after each taken beat
	always @(negedge clk) begin
		if (trees_checked != stall_mark) begin
			stall_mark = trees_checked;
			hold_left  = idle_on ? $urandom_range(0, GAP_MAX) : 0;
		end
		if (hold_left > 0) begin
			out_stall = 1'b1;
			hold_left--;
		end else begin
			out_stall = 1'b0;
		end
	end

	// check each result against the oldest expected tree
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (tree_q.size() == 0) begin
				$display("%0t: result with none expected: weight %0d disconnected %0b",
				         $time, out_data.tree_weight, out_data.disconnected);
				errors++;
			end else begin
				out_item_t want;
				want = tree_q.pop_front();
				if (out_data.tree_weight !== want.tree_weight) begin
					$display("%0t: tree_weight expected %0d actual %0d",
					         $time, want.tree_weight, out_data.tree_weight);
					errors++;
				end
				if (out_data.disconnected !== want.disconnected) begin
					$display("%0t: disconnected expected %0b actual %0b",
					         $time, want.disconnected, out_data.disconnected);
					errors++;
				end
				if (want.disconnected)
					disc_seen++;
			end
			trees_checked++;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			stuck_cycles = 0;
		else
			stuck_cycles++;
		if (stuck_cycles >= STUCK_MAX) begin
			$display("%0t: no beat moved for %0d cycles", $time, STUCK_MAX);
			$display("simulation failed");
			$finish;
		end
	end

	task automatic test_after_reset();
		send_compute(0);
		send_unused();
		send_compute(2);
	endtask

	task automatic test_small_graph();
		set_nodes(4);
		send_load(0, 0, 1, 10);
		send_load(0, 1, 2, 32'hFFFF);
		send_load(0, 2, 3, 0);
		send_load(3, 0, 1, 32'hFFFF);
		send_load(3, 1, 2, 32'hFFFF);
		send_load(3, 3, 2, 32'hFFFF);
		send_compute(0);
		send_compute(3);
		// reload replaces the weight instead of adding a parallel edge
		send_load(0, 2, 1, 1);
		send_compute(0);
		// self loop never joins; equal keys resolve to the lower node
		send_load(0, 3, 3, 0);
		send_load(0, 0, 2, 1);
		send_compute(0);
		// edge past node_count is held but not used yet
		send_load(0, 31, 0, 32'hFFFF);
		send_compute(0);
	endtask

	task automatic test_node_count_limits();
		set_nodes(NODES);
		send_compute(0);
		set_nodes(0);
		send_compute(0);
		set_nodes(63);
		send_compute(0);
		send_clear();
		send_compute(3);
		send_unused();
	endtask

	task automatic test_heavy_chain();
		set_nodes(NODES);
		send_clear();
		for (int i = 0; i < NODES - 1; i++)
			send_load(3, i, i + 1, 32'hFFFF);
		send_compute(3);
	endtask

	task automatic load_pair(input int a, input int b);
		int w;
		if ($urandom_range(0, 3) != 0) begin
			for (int s = 0; s < SCENARIOS; s++) begin
				w = rand_weight();
				send_load(s, a, b, w);
			end
		end else begin
			send_load($urandom_range(0, SCENARIOS - 1), a, b, rand_weight());
		end
	endtask

	task automatic random_round();
		int n_val;
		int span;
		int extra;
		int a;
		int b;
		int s;
		int sel;
		sel = $urandom_range(0, 11);
		if (sel < 7)
			n_val = $urandom_range(2, 8);
		else if (sel < 9)
			n_val = $urandom_range(9, 31);
		else if (sel == 9)
			n_val = NODES;
		else if (sel == 10)
			n_val = $urandom_range(0, 1);
		else
			n_val = $urandom_range(33, 63);
		set_nodes(n_val);
		idle_on = ($urandom_range(0, 3) != 0);
		span = nodes_used;
		if ($urandom_range(0, 1))
			send_clear();
		if ($urandom_range(0, 2) != 0) begin
			for (int i = 1; i < span; i++)
				load_pair(i, $urandom_range(0, i - 1));
		end
		extra = $urandom_range(0, span + 2);
		for (int i = 0; i < extra; i++) begin
			a = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(0, span - 1);
			b = $urandom_range(0, span - 1);
			load_pair(a, b);
			if ($urandom_range(0, 15) == 0)
				send_unused();
		end
		repeat ($urandom_range(1, 3)) begin
			s = $urandom_range(0, SCENARIOS - 1);
			for (int t = 0; t < SCENARIOS && !scen_ready(s); t++)
				s = (s + 1) % SCENARIOS;
			if (scen_ready(s))
				send_compute(s);
		end
	endtask

	task automatic test_random();
		while (items_sent < 580)
			random_round();
	endtask

	initial begin
		arst_n   = 1'b0;
		cfg_we   = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		in_data  = '0;
		out_stall = 1'b0;
		hold_left = 0;
		stall_mark = 0;
		idle_on  = 1'b1;
		errors = 0;
		items_sent = 0;
		loads_sent = 0;
		clears_sent = 0;
		computes_sent = 0;
		trees_checked = 0;
		disc_seen = 0;
		stuck_cycles = 0;
		nodes_used = 1;
		for (int a = 0; a < NODES; a++)
			for (int b = 0; b < NODES; b++) begin
				edge_on[a][b] = 1'b0;
				for (int s = 0; s < SCENARIOS; s++) begin
					edge_wt[s][a][b]  = '0;
					wt_known[s][a][b] = 1'b0;
				end
			end
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_after_reset();
		test_small_graph();
		test_node_count_limits();
		test_heavy_chain();
		test_random();

		in_valid = 1'b0;
		while (tree_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
		$display("covered %0d loads, %0d clears, %0d computes over node counts 0 to 63",
		         loads_sent, clears_sent, computes_sent);
		$display("checked %0d tree results, %0d of them disconnected", trees_checked, disc_seen);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
